### rtl/lz77_pkg.sv
// ---------------------------------------------------------------------------
// lz77_pkg
// Shared types and constants for the level-1 byte decompressor.
// ---------------------------------------------------------------------------
package lz77_pkg;

  localparam int unsigned MaxOutputDef   = 32768;
  localparam int unsigned WindowDepthDef = 8192;
  localparam int unsigned LanesOutDef    = 8;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBadLevel = 3'd1;
  localparam logic [2:0] StOverflow = 3'd2;
  localparam logic [2:0] StBadDist  = 3'd3;
  localparam logic [2:0] StTrunc    = 3'd4;

  typedef enum logic [2:0] {
    PhFirst, PhCtrl, PhLit, PhLong, PhDist, PhDone
  } phase_e;

  typedef enum logic [2:0] {
    FsmIdle, FsmDecode, FsmCopyRd, FsmCopy, FsmEmit
  } fsm_e;

  // controller -> datapath
  typedef struct packed {
    logic take;      // register the input word and decode it
    logic copy_rd;   // issue a history read for the next copy byte
    logic copy_wr;   // write the returned copy byte and pack it
    logic emit;      // present the result word
    logic clr_acc;   // clear the output accumulator
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic start_copy;  // decoded word starts a match copy
    logic copy_last;   // this copy byte is the last of the match
    logic group_full;  // accumulator reaches the lane count with this byte
  } sts_t;

endpackage

### rtl/lz77_ctrl.sv
// ---------------------------------------------------------------------------
// lz77_ctrl
// Sequencer: accepts words, steps match copies, hands out result words.
// ---------------------------------------------------------------------------
module lz77_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  lz77_pkg::sts_t  sts_i,
  output lz77_pkg::cmd_t  cmd_o,
  output logic            out_final_o
);
  import lz77_pkg::*;

  fsm_e state_q, state_d;
  logic copying_q, copying_d;   // the pending emit belongs to a copy
  logic final_q, final_d;       // the pending emit ends the word's output (last copy group or a non-copy result)

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FsmIdle;
      copying_q <= 1'b0;
      final_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      copying_q <= copying_d;
      final_q   <= final_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    copying_d = copying_q;
    final_d   = final_q;
    case (state_q)
      FsmIdle: begin
        if (in_valid_i) state_d = FsmDecode;
      end
      FsmDecode: begin
        if (sts_i.start_copy) begin
          state_d   = FsmCopyRd;
          copying_d = 1'b1;
        end else begin
          state_d   = FsmEmit;
          copying_d = 1'b0;
          final_d   = 1'b1;
        end
      end
      FsmCopyRd: state_d = FsmCopy;
      FsmCopy: begin
        if (sts_i.copy_last || sts_i.group_full) begin
          state_d = FsmEmit;
          final_d = sts_i.copy_last;
        end else begin
          state_d = FsmCopyRd;
        end
      end
      FsmEmit: begin
        if (out_ready_i) begin
          if (copying_q && !final_q) state_d = FsmCopyRd;
          else                       state_d = FsmIdle;
        end
      end
      default: state_d = FsmIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      FsmIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.take   = in_valid_i;
        cmd_o.clr_acc = in_valid_i;
      end
      FsmCopyRd: cmd_o.copy_rd = 1'b1;
      FsmCopy:   cmd_o.copy_wr = 1'b1;
      FsmEmit: begin
        out_valid_o   = 1'b1;
        cmd_o.emit    = 1'b1;
        cmd_o.clr_acc = out_ready_i;
      end
      default: ;
    endcase
  end

  assign out_final_o = final_q;

  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("accept while emitting");
  a_copy_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FsmCopy && sts_i.copy_last) |=> (state_q == FsmEmit && final_q))
    else $error("copy end not emitted");
  a_decode_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == FsmDecode)
    else $error("accept not decoded");

endmodule

### rtl/lz77_dp.sv
// ---------------------------------------------------------------------------
// lz77_dp
// Parse state, history memory, output packing.
// ---------------------------------------------------------------------------
module lz77_dp #(
  parameter int unsigned MAX_OUTPUT   = lz77_pkg::MaxOutputDef,
  parameter int unsigned WINDOW_DEPTH = lz77_pkg::WindowDepthDef,
  parameter int unsigned LANES_OUT    = lz77_pkg::LanesOutDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             code_byte_i,
  input  logic                   first_i,
  input  logic                   last_i,
  input  lz77_pkg::cmd_t         cmd_i,
  input  logic                   final_i,
  output lz77_pkg::sts_t         sts_o,
  output logic [8*LANES_OUT-1:0] out_bytes_o,
  output logic [3:0]             out_count_o,
  output logic [2:0]             status_o,
  output logic                   block_done_o
);
  import lz77_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned PW = $clog2(MAX_OUTPUT + 1);
  localparam int unsigned LW = $clog2(LANES_OUT + 1);

  logic [7:0] mem_q [WINDOW_DEPTH];
  logic [7:0] rdata_q;

  phase_e     phase_q, ph;
  logic [7:0] ctrl_q;
  logic [8:0] mlen_q;
  logic [5:0] lits_q;
  logic [PW-1:0] pos_q;
  logic [2:0] code_q;

  logic [7:0] byte_q;
  logic       first_q, last_q;
  logic       dec_q;
  logic [8:0] left_q;        // copy bytes still to go
  logic [13:0] dist_q;
  logic [8*LANES_OUT-1:0] acc_q;
  logic [LW-1:0] lane_q;
  logic [2:0] rst_q;         // result status
  logic       rdone_q;

  // decode view of phase after an optional block start
  assign ph = first_q ? PhFirst : phase_q;

  logic [16:0] pos_ext;
  logic [5:0]  nlit;
  logic [13:0] dist_c;
  logic [9:0]  tot_c;
  logic        lit_ovf, m_ovf, bad_d;
  logic [2:0]  mcode;
  logic [8:0]  mlen_use;

  always_comb begin
    pos_ext  = first_q ? 17'd0 : 17'(pos_q);
    mlen_use = first_q ? 9'd0 : mlen_q;
    nlit     = ((ph == PhFirst) ? {1'b0, byte_q[4:0]} : byte_q[5:0]) + 6'd1;
    lit_ovf  = (pos_ext + 17'(nlit)) > 17'(MAX_OUTPUT);
    dist_c   = {1'b0, ctrl_q[4:0], byte_q} + 14'd1;
    tot_c    = {1'b0, mlen_use} + 10'd3;
    m_ovf    = (pos_ext + 17'(tot_c)) > 17'(MAX_OUTPUT);
    bad_d    = 17'(dist_c) > pos_ext;
    mcode    = byte_q[7:5] - 3'd1;
  end

  assign sts_o.start_copy = (ph == PhDist) && !m_ovf && !bad_d;
  assign sts_o.copy_last  = (left_q == 9'd1);
  assign sts_o.group_full = (lane_q == LW'(LANES_OUT - 1));

  // history memory: one write, one registered read
  logic [PW-1:0] src_pos;
  assign src_pos = pos_q - PW'(dist_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_rd) rdata_q <= mem_q[src_pos[AW-1:0]];
    if (cmd_i.copy_wr) mem_q[pos_q[AW-1:0]] <= rdata_q;
    else if (dec_q && ph == PhLit) mem_q[pos_q[AW-1:0]] <= byte_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      byte_q  <= code_byte_i;
      first_q <= first_i;
      last_q  <= last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFirst;
      ctrl_q  <= '0;
      mlen_q  <= '0;
      lits_q  <= '0;
      pos_q   <= '0;
      code_q  <= StOk;
      dec_q   <= 1'b0;
      left_q  <= '0;
      dist_q  <= '0;
      acc_q   <= '0;
      lane_q  <= '0;
      rst_q   <= StOk;
      rdone_q <= 1'b0;
    end else begin
      dec_q <= cmd_i.take;
      if (cmd_i.clr_acc) begin
        acc_q  <= '0;
        lane_q <= '0;
      end
      if (dec_q) begin
        if (first_q) begin
          ctrl_q <= '0; mlen_q <= '0; lits_q <= '0; pos_q <= '0; code_q <= StOk;
        end
        rst_q   <= StOk;
        rdone_q <= 1'b0;
        case (ph)
          PhFirst, PhCtrl: begin
            if (ph == PhFirst && byte_q[7:5] != 3'd0) begin
              phase_q <= PhDone; code_q <= StBadLevel;
              rst_q <= StBadLevel; rdone_q <= 1'b1;
            end else if (ph == PhFirst || byte_q < 8'd32) begin
              if (lit_ovf) begin
                phase_q <= PhDone; code_q <= StOverflow;
                rst_q <= StOverflow; rdone_q <= 1'b1;
              end else if (last_q) begin
                phase_q <= PhDone; code_q <= StTrunc;
                rst_q <= StTrunc; rdone_q <= 1'b1;
              end else begin
                lits_q  <= nlit;
                phase_q <= PhLit;
              end
            end else begin
              ctrl_q <= byte_q;
              mlen_q <= {6'd0, mcode};
              if (last_q) begin
                phase_q <= PhDone; code_q <= StTrunc;
                rst_q <= StTrunc; rdone_q <= 1'b1;
              end else begin
                phase_q <= (mcode == 3'd6) ? PhLong : PhDist;
              end
            end
          end
          PhLit: begin
            pos_q  <= pos_q + PW'(1);
            lits_q <= lits_q - 6'd1;
            acc_q  <= {{(8*LANES_OUT-8){1'b0}}, byte_q};
            lane_q <= LW'(1);
            if (last_q) begin
              phase_q <= PhDone;
              code_q  <= (lits_q > 6'd1) ? StTrunc : StOk;
              rst_q   <= (lits_q > 6'd1) ? StTrunc : StOk;
              rdone_q <= 1'b1;
            end else if (lits_q <= 6'd1) begin
              phase_q <= PhCtrl;
            end
          end
          PhLong: begin
            mlen_q  <= mlen_q + {1'b0, byte_q};
            if (last_q) begin
              phase_q <= PhDone; code_q <= StTrunc;
              rst_q <= StTrunc; rdone_q <= 1'b1;
            end else phase_q <= PhDist;
          end
          PhDist: begin
            if (m_ovf) begin
              phase_q <= PhDone; code_q <= StOverflow;
              rst_q <= StOverflow; rdone_q <= 1'b1;
            end else if (bad_d) begin
              phase_q <= PhDone; code_q <= StBadDist;
              rst_q <= StBadDist; rdone_q <= 1'b1;
            end else begin
              left_q  <= tot_c[8:0];
              dist_q  <= dist_c;
              mlen_q  <= '0;
              phase_q <= last_q ? PhDone : PhCtrl;
              if (last_q) code_q <= StOk;
            end
          end
          default: begin
            rst_q   <= code_q;
            rdone_q <= 1'b1;
          end
        endcase
      end
      if (cmd_i.copy_wr) begin
        pos_q  <= pos_q + PW'(1);
        left_q <= left_q - 9'd1;
        acc_q[8*lane_q[$clog2(LANES_OUT+1)-1:0] +: 8] <= rdata_q;
        lane_q <= lane_q + LW'(1);
        if (left_q == 9'd1) rdone_q <= last_q;
      end
    end
  end

  assign out_bytes_o  = acc_q;
  assign out_count_o  = 4'(lane_q);
  assign status_o     = rst_q;
  assign block_done_o = rdone_q & final_i;

  a_lane_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_q <= LW'(LANES_OUT)) else $error("lane overrun");
  a_pos_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(MAX_OUTPUT)) else $error("position overrun");
  a_copy_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.copy_wr |-> left_q != 9'd0) else $error("copy past end");

endmodule

### rtl/lz77_byte_decompressor.sv
// ---------------------------------------------------------------------------
// lz77_byte_decompressor
// Level-1 block decoder taking one compressed byte per word.
// ---------------------------------------------------------------------------
// A word that decodes no or one byte passes the decode and emit states before
// its result leaves; the next word is taken in the idle state that follows.
// Match copies take each copied byte through a read and a write state on the
// single history read port, with an emit state per group of up to LANES_OUT bytes.
// Reset clears parse state and position; history is not cleared.
module lz77_byte_decompressor #(
  parameter int unsigned MAX_OUTPUT   = lz77_pkg::MaxOutputDef,
  parameter int unsigned WINDOW_DEPTH = lz77_pkg::WindowDepthDef,
  parameter int unsigned LANES_OUT    = lz77_pkg::LanesOutDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // code_byte
  input  logic        s_axis_tuser,   // first_of_block
  input  logic        s_axis_tlast,   // last_of_block
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_bytes[63:0], out_count[67:64], status[70:68]
  output logic        m_axis_tuser,   // block_done
  output logic        m_axis_tlast    // run_last
);
  import lz77_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic fin;
  logic [8*LANES_OUT-1:0] bytes;
  logic [3:0] cnt;
  logic [2:0] st;

  lz77_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd), .out_final_o(fin)
  );

  lz77_dp #(.MAX_OUTPUT(MAX_OUTPUT), .WINDOW_DEPTH(WINDOW_DEPTH),
            .LANES_OUT(LANES_OUT)) u_dp (
    .clk_i, .rst_ni,
    .code_byte_i(s_axis_tdata), .first_i(s_axis_tuser), .last_i(s_axis_tlast),
    .cmd_i(cmd), .final_i(fin), .sts_o(sts),
    .out_bytes_o(bytes), .out_count_o(cnt), .status_o(st), .block_done_o(m_axis_tuser)
  );

  // pad unused lanes with zeros
  assign m_axis_tdata = {1'b0, st, cnt, 64'(bytes)};
  assign m_axis_tlast = fin;

endmodule

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the level-1 byte decompressor: a behavioural
// decoder predicts every result word, a checker compares them in order.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lz77_pkg::*;

  localparam int MaxOut = 32768;
  localparam int Window = 8192;
  localparam int Lanes  = 8;
  localparam longint CycleLimit = 2000000;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic [2:0]  status;
    logic        run_last;
    logic        done;
  } dec_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  always #6 clk_i = ~clk_i;

  lz77_byte_decompressor DUT (.*);

  // decoder copy of the block state
  logic [7:0]  hist [Window];
  phase_e      ph;
  logic [7:0]  ctl_hold;
  int unsigned mlen, lit_left, opos;
  logic [2:0]  done_st;

  dec_word_t   pending_words [$];
  int          errors = 0;
  longint      cycles = 0;
  bit          hold_off = 1'b0;
  bit          flood = 1'b0;
  int          rx_gap = 0;

  task automatic clear_block();
    ph = PhFirst; ctl_hold = '0; mlen = 0; lit_left = 0; opos = 0; done_st = StOk;
  endtask

  function automatic dec_word_t mk(logic [63:0] b, int c, logic [2:0] s, bit l, bit d);
    dec_word_t w;
    w.bytes = b; w.count = c[3:0]; w.status = s; w.run_last = l; w.done = d;
    return w;
  endfunction

  task automatic stop_block(logic [2:0] code);
    ph = PhDone; done_st = code;
    pending_words.push_back(mk('0, 0, code, 1, 1));
  endtask

  task automatic open_literals(int unsigned n, bit lastb);
    if (opos + n > MaxOut) stop_block(StOverflow);
    else if (lastb) stop_block(StTrunc);
    else begin
      lit_left = n; ph = PhLit;
      pending_words.push_back(mk('0, 0, StOk, 1, 0));
    end
  endtask

  // Predict the result words caused by one accepted code word.
  task automatic decode_byte(logic [7:0] b, bit first, bit lastb);
    int unsigned span, total, lane;
    logic [63:0] acc;
    logic [7:0] cb;
    if (first) clear_block();
    case (ph)
      PhFirst: begin
        if (b[7:5] != 0) stop_block(StBadLevel);
        else open_literals(b[4:0] + 1, lastb);
      end
      PhCtrl: begin
        if (b < 32) open_literals(b + 1, lastb);
        else begin
          ctl_hold = b; mlen = b[7:5] - 1;
          ph = (mlen == 6) ? PhLong : PhDist;
          if (lastb) stop_block(StTrunc);
          else pending_words.push_back(mk('0, 0, StOk, 1, 0));
        end
      end
      PhLit: begin
        hist[opos % Window] = b; opos++;
        if (lit_left > 0) lit_left--;
        if (lit_left == 0) ph = PhCtrl;
        if (lastb) begin
          done_st = (lit_left > 0) ? StTrunc : StOk;
          ph = PhDone;
          pending_words.push_back(mk({56'd0, b}, 1, done_st, 1, 1));
        end else pending_words.push_back(mk({56'd0, b}, 1, StOk, 1, 0));
      end
      PhLong: begin
        mlen = (mlen + b) & 9'h1ff; ph = PhDist;
        if (lastb) stop_block(StTrunc);
        else pending_words.push_back(mk('0, 0, StOk, 1, 0));
      end
      PhDist: begin
        span = (int'(ctl_hold[4:0]) << 8) + b + 1;
        total = mlen + 3;
        if (opos + total > MaxOut) stop_block(StOverflow);
        else if (span > opos) stop_block(StBadDist);
        else begin
          lane = 0; acc = '0;
          for (int unsigned i = 0; i < total; i++) begin
            cb = hist[(opos - span) % Window];
            hist[opos % Window] = cb; opos++;
            acc |= 64'(cb) << (8 * lane); lane++;
            if (lane == Lanes || i + 1 == total) begin
              pending_words.push_back(mk(acc, lane, StOk, i + 1 == total,
                                         (i + 1 == total) && lastb));
              lane = 0; acc = '0;
            end
          end
          mlen = 0;
          ph = lastb ? PhDone : PhCtrl;
          if (lastb) done_st = StOk;
        end
      end
      default: pending_words.push_back(mk('0, 0, done_st, 1, 1));
    endcase
  endtask

  // Offer one word; it is taken at the rising edge with tready high.
  // Hold tvalid after acceptance unless a gap follows.
  task automatic send_code(logic [7:0] b, bit first = 0, bit lastb = 0);
    if (!flood && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1; s_axis_tdata <= b; s_axis_tuser <= first; s_axis_tlast <= lastb;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(b, first, lastb);
    @(negedge clk_i);
  endtask

  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // Literal run of n bytes (1..32), random content.
  task automatic send_literals(int n, bit first = 0, bit lastb = 0);
    send_code(8'(n - 1), first, 0);
    for (int i = 0; i < n; i++) send_code(8'($urandom), 0, lastb && i == n - 1);
  endtask

  // Match with length code 0..6 (+extra) and distance; the distance is not checked against the output so far.
  task automatic send_match(int unsigned code, int unsigned extra, int unsigned span,
                            bit lastb = 0);
    send_code({3'(code + 1), 5'((span - 1) >> 8)}, 0, 0);
    if (code == 6) send_code(8'(extra), 0, 0);
    send_code(8'(span - 1), 0, lastb);
  endtask

  task automatic test_directed();
    send_literals(1, 1);
    send_match(0, 0, 1);                 // shortest overlapping copy
    send_literals(32);
    send_match(6, 255, 33);              // longest match
    send_match(5, 0, 10, 1);             // clean end on a match
    send_code(8'h55);                    // after end: answered with the final status
    send_code(8'hE0, 1);                 // bad level
    send_literals(2, 1);
    send_match(1, 0, 3);                 // distance before start
    send_literals(1, 1);
    send_code(8'h1F, 0, 1);              // truncation on a run control byte
    send_literals(3, 1, 0);
    send_code(8'h02);
    send_code(8'hFF, 0, 1);              // truncated literal, still given out
    send_literals(1, 1);
    send_code(8'hE0); send_code(8'h00, 0, 1);   // truncation at the extra length byte
    drain_all();
  endtask

  task automatic random_block(int words);
    int n;
    int unsigned code, span;
    send_literals($urandom_range(1, 8), 1);
    while (words > 0) begin
      n = $urandom_range(0, 9);
      if (n < 3) begin
        n = $urandom_range(1, 8); send_literals(n); words -= n + 1;
      end else if (n < 9) begin
        code = $urandom_range(0, 6);
        span = $urandom_range(1, opos < 8192 ? opos : 8192);
        if ($urandom_range(0, 5) == 0) span = $urandom_range(1, 8192);
        send_match(code, code == 6 ? $urandom_range(0, 20) : 0, span);
        words -= 3;
      end else begin
        send_code(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
        words--;
      end
    end
    send_literals($urandom_range(1, 4), 0, 1);
  endtask

  task automatic test_random();
    repeat (2) random_block(10);
    drain_all();
  endtask

  // Receiver holds off while the sender keeps offering words.
  task automatic test_backpressure();
    hold_off = 1;
    flood = 1;
    fork
      begin repeat (300) @(negedge clk_i); hold_off = 0; end
      random_block(8);
    join
    flood = 0;
    drain_all();
  endtask

  // receiver: random stalls, mostly short and a few long, sampled at rising edge
  always @(negedge clk_i) begin
    if (rx_gap > 0) rx_gap <= rx_gap - 1;
    else if ($urandom_range(0, 7) == 0)
      rx_gap <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    m_axis_tready <= !hold_off && rst_ni && rx_gap == 0;
  end

  always @(posedge clk_i) begin
    dec_word_t got, want;
    cycles <= cycles + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      got = mk(m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tdata[70:68],
               m_axis_tlast, m_axis_tuser);
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h", $time, got);
      end else begin
        want = pending_words.pop_front();
        if (got.bytes !== want.bytes || got.count !== want.count ||
            got.status !== want.status || got.run_last !== want.run_last ||
            got.done !== want.done) begin
          errors++;
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
        end
      end
    end
  end

  always @(posedge clk_i)
    if (cycles > CycleLimit) begin
      $display("[lz77_byte_decompressor] ERROR");
      $finish;
    end

  initial begin
    clear_block();
    for (int i = 0; i < Window; i++) hist[i] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    if (errors == 0 && pending_words.size() == 0)
      $display("[lz77_byte_decompressor] OK");
    else
      $display("[lz77_byte_decompressor] ERROR");
    $finish;
  end

endmodule
